[src/mips_subset_execute_macros.svh]
// ----------------------------------------------------------------------------
// mips_subset_execute_macros
// Assertion macros shared by the core's RTL files.
// Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_EXECUTE_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_MACROS_SVH

// Same-cycle implication.
`define MSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types of the MIPS subset execute core.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);

  localparam logic [31:0] START_RESET = 32'h0040_0000;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // Memory request codes
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [REG_AW-1:0] REG_RA = REG_AW'(REG_COUNT - 1);

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [31:0]       data;
  } rf_wr_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr_a;
    logic [REG_AW-1:0] addr_b;
  } rf_rd_t;

endpackage

[src/mse_if.sv]
// ----------------------------------------------------------------------------
// mse_if
// Valid/ready channels of the core: instruction/load input, result, config.
// ----------------------------------------------------------------------------
interface mse_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] instruction_word;
  logic [31:0] load_data;

  modport source (output valid, kind, instruction_word, load_data, input ready);
  modport sink   (input valid, kind, instruction_word, load_data, output ready);
endinterface

interface mse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_address;
  logic [1:0]  mem_request;
  logic [31:0] mem_address;
  logic [31:0] store_data;
  logic        halted;

  modport source (output valid, fetch_address, mem_request, mem_address, store_data,
                  halted, input ready);
  modport sink   (input valid, fetch_address, mem_request, mem_address, store_data,
                  halted, output ready);
endinterface

interface mse_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[src/mse_regfile.sv]
// ----------------------------------------------------------------------------
// mse_regfile
// 32 x 32 register file, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`include "mips_subset_execute_macros.svh"

module mse_regfile (
  input  logic            clk,
  input  logic            rst_n,
  input  mse_pkg::rf_rd_t rd,
  input  mse_pkg::rf_wr_t wr,
  output logic [31:0]     rd_a,
  output logic [31:0]     rd_b
);
  import mse_pkg::*;

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [31:0]          rd_a_r;
  logic [31:0]          rd_b_r;
  logic                 wr_ok;

  // r0 is never written, so its valid bit stays low and it reads zero
  assign wr_ok = wr.en && (wr.addr != '0);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  // Write-first: a read in the same cycle as a write to that entry sees the new data
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (wr_ok && wr.addr == rd.addr_a) begin
        rd_a_r <= wr.data;
      end else begin
        rd_a_r <= vld_r[rd.addr_a] ? mem[rd.addr_a] : '0;
      end
      if (wr_ok && wr.addr == rd.addr_b) begin
        rd_b_r <= wr.data;
      end else begin
        rd_b_r <= vld_r[rd.addr_b] ? mem[rd.addr_b] : '0;
      end
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

  `MSE_ASSERT_NOW(a_r0_never_valid, 1'b1, !vld_r[0], "r0 marked as written")
  `MSE_ASSERT_NEXT(a_r0_reads_zero_a, rd.en && rd.addr_a == '0, rd_a_r == '0, "r0 read nonzero")
  `MSE_ASSERT_NEXT(a_r0_reads_zero_b, rd.en && rd.addr_b == '0, rd_b_r == '0, "r0 read nonzero")

endmodule

[src/mips_subset_execute.sv]
// ----------------------------------------------------------------------------
// mips_subset_execute
// MIPS-32 subset core: one instruction or load-return transfer in, one result out.
// ----------------------------------------------------------------------------
// The core takes one input transfer per clock while the result channel is not
// stalled and returns one result per transfer, through an input register (with
// the register file read alongside it) and a result register. An lw result asks
// for a word read; the returned word must come back as the next input
// (kind 1) before any instruction is executed, so a load costs two input
// transfers. Writing cfg sets the PC at once. An all-zero word halts the core
// until reset. There is no clearing pass after reset.
`include "mips_subset_execute_macros.svh"

module mips_subset_execute (
  input logic      clk,
  input logic      rst_n,
  mse_in_if.sink   in_chan,
  mse_out_if.source out_chan,
  mse_cfg_if.sink  cfg_chan
);
  import mse_pkg::*;

  // Input stage
  logic        s1_v_r;
  logic        s1_kind_r;
  logic [31:0] s1_word_r;
  logic [31:0] s1_ld_r;

  // Architectural state
  logic [31:0]       pc_r,  pc_nxt;
  logic              run_r, run_nxt;
  logic              lp_r,  lp_nxt;
  logic [REG_AW-1:0] lt_r,  lt_nxt;

  // Result register
  logic        out_v_r;
  logic [31:0] out_pc_r;
  logic [1:0]  out_req_r,   req_nxt;
  logic [31:0] out_maddr_r, maddr_nxt;
  logic [31:0] out_sdata_r, sdata_nxt;
  logic        out_halt_r;

  logic        in_fire, exec_fire;
  rf_rd_t      rf_rd;
  rf_wr_t      rf_wr;
  logic [31:0] op_a, op_b;

  // Decode
  logic [5:0]        opc, fn;
  logic [REG_AW-1:0] rt, rd;
  logic [4:0]        sh;
  logic [31:0]       imm_z, imm_s, pc4, jtgt, sum_ai;

  assign exec_fire = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !s1_v_r || exec_fire;
  assign in_fire = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign rf_rd.en     = in_fire;
  assign rf_rd.addr_a = in_chan.instruction_word[25:21];
  assign rf_rd.addr_b = in_chan.instruction_word[20:16];

  mse_regfile u_rf (
    .clk  (clk),
    .rst_n(rst_n),
    .rd   (rf_rd),
    .wr   (rf_wr),
    .rd_a (op_a),
    .rd_b (op_b)
  );

  assign opc    = s1_word_r[31:26];
  assign rt     = s1_word_r[20:16];
  assign rd     = s1_word_r[15:11];
  assign sh     = s1_word_r[10:6];
  assign fn     = s1_word_r[5:0];
  assign imm_z  = {16'h0, s1_word_r[15:0]};
  assign imm_s  = {{16{s1_word_r[15]}}, s1_word_r[15:0]};
  assign pc4    = pc_r + 32'd4;
  assign jtgt   = {pc4[31:28], s1_word_r[25:0], 2'b00};
  assign sum_ai = op_a + imm_s;

  always_comb begin
    pc_nxt    = pc_r;
    run_nxt   = run_r;
    lp_nxt    = lp_r;
    lt_nxt    = lt_r;
    req_nxt   = REQ_NONE;
    maddr_nxt = '0;
    sdata_nxt = '0;
    rf_wr     = '0;
    if (exec_fire && run_r) begin
      if (s1_kind_r) begin
        if (lp_r) begin
          rf_wr.en   = 1'b1;
          rf_wr.addr = lt_r;
          rf_wr.data = s1_ld_r;
          lp_nxt     = 1'b0;
        end
      end else if (!lp_r) begin
        pc_nxt = pc4;
        if (s1_word_r == '0) begin
          run_nxt = 1'b0;
          pc_nxt  = pc_r;
        end else if (opc == OP_SPECIAL) begin
          rf_wr.addr = rd;
          case (fn)
            FN_ADD, FN_ADDU: begin
              rf_wr.en = 1'b1; rf_wr.data = op_a + op_b;
            end
            FN_SUB, FN_SUBU: begin
              rf_wr.en = 1'b1; rf_wr.data = op_a - op_b;
            end
            FN_AND: begin
              rf_wr.en = 1'b1; rf_wr.data = op_a & op_b;
            end
            FN_OR: begin
              rf_wr.en = 1'b1; rf_wr.data = op_a | op_b;
            end
            FN_NOR: begin
              rf_wr.en = 1'b1; rf_wr.data = ~(op_a | op_b);
            end
            FN_SLTU: begin
              rf_wr.en = 1'b1; rf_wr.data = {31'h0, op_a < op_b};
            end
            FN_SLL: begin
              rf_wr.en = 1'b1; rf_wr.data = op_b << sh;
            end
            FN_SRL: begin
              rf_wr.en = 1'b1; rf_wr.data = op_b >> sh;
            end
            FN_JR: pc_nxt = op_a;
            default: ;
          endcase
        end else begin
          rf_wr.addr = rt;
          case (opc)
            OP_ADDIU: begin
              rf_wr.en = 1'b1; rf_wr.data = sum_ai;
            end
            OP_ANDI: begin
              rf_wr.en = 1'b1; rf_wr.data = op_a & imm_z;
            end
            OP_ORI: begin
              rf_wr.en = 1'b1; rf_wr.data = op_a | imm_z;
            end
            OP_SLTIU: begin
              rf_wr.en = 1'b1; rf_wr.data = {31'h0, op_a < imm_s};
            end
            OP_LUI: begin
              rf_wr.en = 1'b1; rf_wr.data = {s1_word_r[15:0], 16'h0};
            end
            OP_BEQ: begin
              if (op_a == op_b) pc_nxt = pc4 + {imm_s[29:0], 2'b00};
            end
            OP_BNE: begin
              if (op_a != op_b) pc_nxt = pc4 + {imm_s[29:0], 2'b00};
            end
            OP_LW: begin
              req_nxt   = REQ_READ;
              maddr_nxt = sum_ai;
              lp_nxt    = 1'b1;
              lt_nxt    = rt;
            end
            OP_SW: begin
              req_nxt   = REQ_WRITE;
              maddr_nxt = sum_ai;
              sdata_nxt = op_b;
            end
            OP_J: pc_nxt = jtgt;
            OP_JAL: begin
              rf_wr.en   = 1'b1;
              rf_wr.addr = REG_RA;
              rf_wr.data = pc_r + 32'd8;
              pc_nxt     = jtgt;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pc_r    <= START_RESET;
      run_r   <= 1'b1;
      lp_r    <= 1'b0;
      lt_r    <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (exec_fire) begin
        s1_v_r <= 1'b0;
      end
      if (exec_fire) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
      run_r <= run_nxt;
      lp_r  <= lp_nxt;
      lt_r  <= lt_nxt;
      // the user must send config transfers only while idle; the block does not enforce it
      if (cfg_chan.valid) begin
        pc_r <= cfg_chan.data;
      end else begin
        pc_r <= pc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_chan.kind;
      s1_word_r <= in_chan.instruction_word;
      s1_ld_r   <= in_chan.load_data;
    end
    if (exec_fire) begin
      out_pc_r    <= pc_nxt;
      out_req_r   <= req_nxt;
      out_maddr_r <= maddr_nxt;
      out_sdata_r <= sdata_nxt;
      out_halt_r  <= !run_nxt;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.fetch_address = out_pc_r;
  assign out_chan.mem_request   = out_req_r;
  assign out_chan.mem_address   = out_maddr_r;
  assign out_chan.store_data    = out_sdata_r;
  assign out_chan.halted        = out_halt_r;

  `MSE_ASSERT_NEXT(a_halt_sticky, !run_r, !run_r, "core restarted after halt")
  `MSE_ASSERT_NOW(a_halted_no_req, out_v_r && out_halt_r, out_req_r == REQ_NONE,
                  "memory request from halted core")
  `MSE_ASSERT_NEXT(a_lw_sets_pending, exec_fire && req_nxt == REQ_READ, lp_r,
                   "load issued without pending flag")

endmodule
